[hdl/ipr_pkg.sv]
// Shared types, codes and helper functions for the inclinometer poll and retry decoder.
// Used by the channel interfaces and by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ipr_pkg;

   // Event codes carried by an input transaction.
   typedef enum logic [1:0] {
      ACT_START         = 2'd0,
      ACT_POWER_EXPIRED = 2'd1,
      ACT_TIMEOUT       = 2'd2,
      ACT_REPLY         = 2'd3
   } action_type;

   // Command codes carried by a result transaction.
   typedef enum logic [2:0] {
      CMD_POWER_ON = 3'd0,
      CMD_REQUEST  = 3'd1,
      CMD_RECORD   = 3'd2,
      CMD_END      = 3'd3,
      CMD_RELEASE  = 3'd4
   } cmd_type;

   // Phase of the reading sequence.
   typedef enum logic [1:0] {
      PH_INIT     = 2'd0,
      PH_POWER_ON = 2'd1,
      PH_COLLECT  = 2'd2,
      PH_END      = 2'd3
   } phase_type;

   // Register indexes of the configuration port.
   typedef enum logic [1:0] {
      REG_POWER_WAIT    = 2'd0,
      REG_REPLY_TIMEOUT = 2'd1,
      REG_RETRY_LIMIT   = 2'd2,
      REG_DEGREE_LIMIT  = 2'd3
   } reg_index_type;

   localparam logic [15:0] POWER_WAIT_RESET    = 16'd1000;
   localparam logic [15:0] REPLY_TIMEOUT_RESET = 16'd1000;
   localparam logic [3:0]  RETRY_LIMIT_RESET   = 4'd3;
   localparam logic [9:0]  DEGREE_LIMIT_RESET  = 10'd30;
   localparam logic [3:0]  FAIL_MAX            = 4'hf;
   localparam logic [10:0] DEG_HUNDRED         = 11'd100;
   localparam logic [14:0] FRAC_HUNDRED        = 15'd100;
   localparam logic [7:0]  BCD_CORRECTION      = 8'd6;

   // One input transaction as held in the input register.
   typedef struct packed {
      action_type  action;
      logic [7:0]  battery_level;
      logic [7:0]  x_sign_hundreds;
      logic [7:0]  x_degrees_low;
      logic [7:0]  x_fraction_high;
      logic [7:0]  x_fraction_low;
      logic [7:0]  y_sign_hundreds;
      logic [7:0]  y_degrees_low;
      logic [7:0]  y_fraction_high;
      logic [7:0]  y_fraction_low;
   } item_type;

   // Packed record bytes that accompany a record command.
   typedef struct packed {
      logic [7:0] signs_byte;
      logic [7:0] x_degrees_byte;
      logic [7:0] x_fraction_lsb;
      logic [7:0] x_fraction_msb;
      logic [7:0] y_degrees_byte;
      logic [7:0] y_fraction_lsb;
      logic [7:0] y_fraction_msb;
      logic [7:0] record_battery;
   } record_type;

   // Outcome of decoding a sensor frame.
   typedef struct packed {
      logic       rejected;
      record_type record;
   } frame_eval_type;

   // Up to three commands produced by one event, oldest first.
   typedef struct packed {
      logic [1:0]            count;
      cmd_type [2:0]         cmd;
   } run_type;

   // Decode one BCD byte: each high nibble step counts ten, not sixteen.
   function automatic logic [7:0] bcd_to_bin(input logic [7:0] b);
      logic [7:0] tens;
      tens = {4'd0, b[7:4]};
      return b - 8'(tens * BCD_CORRECTION);
   endfunction

endpackage

`default_nettype wire

[hdl/ipr_if.sv]
// Valid/ready channel interfaces for the event input and the command output.
// Depends on ipr_pkg for the action and command codes.
`timescale 1ns / 1ps
`default_nettype none

interface ipr_req_if;
   logic                valid;
   logic                ready;
   ipr_pkg::action_type action;
   logic [7:0]          battery_level;
   logic [7:0]          x_sign_hundreds;
   logic [7:0]          x_degrees_low;
   logic [7:0]          x_fraction_high;
   logic [7:0]          x_fraction_low;
   logic [7:0]          y_sign_hundreds;
   logic [7:0]          y_degrees_low;
   logic [7:0]          y_fraction_high;
   logic [7:0]          y_fraction_low;

   modport source (
      output valid, action, battery_level, x_sign_hundreds, x_degrees_low,
             x_fraction_high, x_fraction_low, y_sign_hundreds, y_degrees_low,
             y_fraction_high, y_fraction_low,
      input  ready
   );
   modport sink (
      input  valid, action, battery_level, x_sign_hundreds, x_degrees_low,
             x_fraction_high, x_fraction_low, y_sign_hundreds, y_degrees_low,
             y_fraction_high, y_fraction_low,
      output ready
   );
endinterface

interface ipr_rsp_if;
   logic             valid;
   logic             ready;
   ipr_pkg::cmd_type command;
   logic             last_of_run;
   logic [15:0]      timer_length_ms;
   logic [7:0]       signs_byte;
   logic [7:0]       x_degrees_byte;
   logic [7:0]       x_fraction_lsb;
   logic [7:0]       x_fraction_msb;
   logic [7:0]       y_degrees_byte;
   logic [7:0]       y_fraction_lsb;
   logic [7:0]       y_fraction_msb;
   logic [7:0]       record_battery;

   modport source (
      output valid, command, last_of_run, timer_length_ms, signs_byte,
             x_degrees_byte, x_fraction_lsb, x_fraction_msb, y_degrees_byte,
             y_fraction_lsb, y_fraction_msb, record_battery,
      input  ready
   );
   modport sink (
      input  valid, command, last_of_run, timer_length_ms, signs_byte,
             x_degrees_byte, x_fraction_lsb, x_fraction_msb, y_degrees_byte,
             y_fraction_lsb, y_fraction_msb, record_battery,
      output ready
   );
endinterface

`default_nettype wire

[hdl/ipr_frame_decode.sv]
// Combinational decode of the eight sensor frame bytes into record bytes and a plausibility flag.
// Depends on ipr_pkg for the item and record types and the BCD helper.
`timescale 1ns / 1ps
`default_nettype none

module ipr_frame_decode (
   input  wire ipr_pkg::item_type       item,
   input  wire logic [9:0]              degree_limit,
   output ipr_pkg::frame_eval_type      eval
);
   import ipr_pkg::*;

   logic [10:0] x_degrees;
   logic [10:0] y_degrees;
   logic [14:0] x_fraction;
   logic [14:0] y_fraction;

   // Whole degrees: hundreds nibble times one hundred plus the decoded tens and units.
   always_comb begin
      x_degrees = 11'(item.x_sign_hundreds[3:0]) * DEG_HUNDRED
                + 11'(bcd_to_bin(item.x_degrees_low));
      y_degrees = 11'(item.y_sign_hundreds[3:0]) * DEG_HUNDRED
                + 11'(bcd_to_bin(item.y_degrees_low));
   end

   // Fractions: high digit pair times one hundred plus the low digit pair.
   always_comb begin
      x_fraction = 15'(bcd_to_bin(item.x_fraction_high)) * FRAC_HUNDRED
                 + 15'(bcd_to_bin(item.x_fraction_low));
      y_fraction = 15'(bcd_to_bin(item.y_fraction_high)) * FRAC_HUNDRED
                 + 15'(bcd_to_bin(item.y_fraction_low));
   end

   // The reading is implausible only when both axes exceed the limit.
   always_comb begin
      eval.rejected              = (x_degrees > {1'b0, degree_limit})
                                && (y_degrees > {1'b0, degree_limit});
      eval.record.signs_byte     = {item.x_sign_hundreds[7:4], item.y_sign_hundreds[7:4]};
      eval.record.x_degrees_byte = x_degrees[7:0];
      eval.record.x_fraction_lsb = x_fraction[7:0];
      eval.record.x_fraction_msb = {1'b0, x_fraction[14:8]};
      eval.record.y_degrees_byte = y_degrees[7:0];
      eval.record.y_fraction_lsb = y_fraction[7:0];
      eval.record.y_fraction_msb = {1'b0, y_fraction[14:8]};
      eval.record.record_battery = 8'd0;
   end

endmodule

`default_nettype wire

[hdl/ipr_sequencer.sv]
// Reading sequencer: holds phase, failure count and battery, and turns one event into commands.
// Depends on ipr_pkg for codes and types; fed by ipr_frame_decode.
`timescale 1ns / 1ps
`default_nettype none

module ipr_sequencer (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    load,
   input  wire ipr_pkg::item_type       item,
   input  wire ipr_pkg::frame_eval_type eval,
   input  wire logic [3:0]              retry_limit,
   output ipr_pkg::run_type             run,
   output ipr_pkg::record_type          record
);
   import ipr_pkg::*;

   phase_type  phase_ff;
   phase_type  phase_in;
   logic [3:0] fail_count_ff;
   logic [3:0] fail_count_in;
   logic [7:0] held_battery_ff;
   logic [7:0] held_battery_in;
   logic [3:0] fail_bumped;

   // Sequence state is updated when the event is handed to the result queue.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_INIT;
         fail_count_ff   <= 4'd0;
         held_battery_ff <= 8'd0;
      end else if (load) begin
         phase_ff        <= phase_in;
         fail_count_ff   <= fail_count_in;
         held_battery_ff <= held_battery_in;
      end
   end

   // Failure count that saturates at its maximum.
   assign fail_bumped = (fail_count_ff == FAIL_MAX) ? FAIL_MAX : fail_count_ff + 4'd1;

   // The record always carries the battery level held at the last start.
   always_comb begin
      record                = eval.record;
      record.record_battery = held_battery_ff;
   end

   // Decision for one event: next state and the list of commands.
   always_comb begin
      phase_in        = phase_ff;
      fail_count_in   = fail_count_ff;
      held_battery_in = held_battery_ff;
      run.count       = 2'd1;
      run.cmd[0]      = CMD_RELEASE;
      run.cmd[1]      = CMD_END;
      run.cmd[2]      = CMD_END;
      unique case (item.action)
         ACT_START: begin
            held_battery_in = item.battery_level;
            phase_in        = PH_POWER_ON;
            run.cmd[0]      = CMD_POWER_ON;
         end
         ACT_POWER_EXPIRED: begin
            phase_in   = PH_COLLECT;
            run.cmd[0] = CMD_REQUEST;
         end
         ACT_TIMEOUT: begin
            if (fail_count_ff >= retry_limit) begin
               fail_count_in = 4'd0;
               phase_in      = PH_END;
               run.count     = 2'd2;
            end else begin
               phase_in      = PH_COLLECT;
               fail_count_in = fail_bumped;
               run.cmd[0]    = CMD_REQUEST;
            end
         end
         ACT_REPLY: begin
            // Release comes first; the reply only counts while collecting.
            if (phase_ff == PH_COLLECT) begin
               run.count = 2'd2;
               if (eval.rejected) begin
                  if (fail_bumped >= retry_limit) begin
                     fail_count_in = 4'd0;
                     phase_in      = PH_END;
                  end else begin
                     fail_count_in = fail_bumped;
                     run.cmd[1]    = CMD_REQUEST;
                  end
               end else begin
                  fail_count_in = 4'd0;
                  phase_in      = PH_END;
                  run.count     = 2'd3;
                  run.cmd[1]    = CMD_RECORD;
               end
            end
         end
      endcase
   end

endmodule

`default_nettype wire

[hdl/ipr_result_queue.sv]
// Result register that plays out the commands of one event, one transaction per cycle while the receiver is ready.
// Depends on ipr_pkg for the run and record types and the command codes.
`timescale 1ns / 1ps
`default_nettype none

module ipr_result_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire ipr_pkg::run_type    run,
   input  wire ipr_pkg::record_type record,
   input  wire logic [15:0]         power_wait_ms,
   input  wire logic [15:0]         reply_timeout_ms,
   output logic                     free,
   ipr_rsp_if.source                rsp
);
   import ipr_pkg::*;

   cmd_type    cmd_ff [3];
   logic [1:0] left_ff;
   record_type record_ff;
   logic       take;
   logic       is_record;

   assign take      = rsp.valid && rsp.ready;
   assign free      = (left_ff == 2'd0) || (take && rsp.last_of_run);
   assign is_record = (cmd_ff[0] == CMD_RECORD);

   // Remaining command count; the oldest command sits in entry zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= 2'd0;
      end else if (load) begin
         left_ff <= run.count;
      end else if (take) begin
         left_ff <= left_ff - 2'd1;
      end
   end

   // Command entries and record bytes; entries shift down as transactions leave.
   always_ff @(posedge clock) begin
      if (load) begin
         cmd_ff[0] <= run.cmd[0];
         cmd_ff[1] <= run.cmd[1];
         cmd_ff[2] <= run.cmd[2];
         record_ff <= record;
      end else if (take) begin
         cmd_ff[0] <= cmd_ff[1];
         cmd_ff[1] <= cmd_ff[2];
      end
   end

   // Result fields; record bytes are shown only with the record command.
   always_comb begin
      rsp.valid       = (left_ff != 2'd0);
      rsp.command     = cmd_ff[0];
      rsp.last_of_run = (left_ff == 2'd1);
      priority if (cmd_ff[0] == CMD_POWER_ON) begin
         rsp.timer_length_ms = power_wait_ms;
      end else if (cmd_ff[0] == CMD_REQUEST) begin
         rsp.timer_length_ms = reply_timeout_ms;
      end else begin
         rsp.timer_length_ms = 16'd0;
      end
      rsp.signs_byte     = is_record ? record_ff.signs_byte     : 8'd0;
      rsp.x_degrees_byte = is_record ? record_ff.x_degrees_byte : 8'd0;
      rsp.x_fraction_lsb = is_record ? record_ff.x_fraction_lsb : 8'd0;
      rsp.x_fraction_msb = is_record ? record_ff.x_fraction_msb : 8'd0;
      rsp.y_degrees_byte = is_record ? record_ff.y_degrees_byte : 8'd0;
      rsp.y_fraction_lsb = is_record ? record_ff.y_fraction_lsb : 8'd0;
      rsp.y_fraction_msb = is_record ? record_ff.y_fraction_msb : 8'd0;
      rsp.record_battery = is_record ? record_ff.record_battery : 8'd0;
   end

   // A new run is only loaded once the previous one has fully left.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> free)
      else $error("run loaded over undelivered commands");

   // A record is never the final command of a run.
   a_record_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && is_record |-> left_ff == 2'd2)
      else $error("record command not followed by end");

   // Taking a non-final transaction leaves the next one waiting.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      take && !rsp.last_of_run |=> rsp.valid)
      else $error("run stopped before its last transaction");

   // The last transaction of a run is never a record.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.last_of_run |-> rsp.command == CMD_POWER_ON
         || rsp.command == CMD_REQUEST || rsp.command == CMD_END
         || rsp.command == CMD_RELEASE)
      else $error("run ended on a record");

endmodule

`default_nettype wire

[hdl/inclinometer_poll_retry_decoder.sv]
// Top level of the inclinometer poll and retry decoder: input register, configuration registers.
// Depends on ipr_pkg, ipr_if, ipr_frame_decode, ipr_sequencer and ipr_result_queue.
`timescale 1ns / 1ps
`default_nettype none

// Each event transaction (start, power wait expired, reply timeout, reply received) yields one
// to three command transactions on the response channel, the last flagged by last_of_run. An
// event is taken into an input register, decoded in a single pass and handed to the result
// register once that register is free; the result register then issues one command per cycle
// while the response channel is ready. A new event is accepted into the input register while
// the previous commands are still being delivered. Configuration registers should be written
// only while no event is in flight.
module inclinometer_poll_retry_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_write_data,
   ipr_req_if.sink          req_chan,
   ipr_rsp_if.source        rsp_chan
);
   import ipr_pkg::*;

   logic           in_valid_ff;
   item_type       item_ff;
   logic [15:0]    power_wait_ff;
   logic [15:0]    reply_timeout_ff;
   logic [3:0]     retry_limit_ff;
   logic [9:0]     degree_limit_ff;
   logic           queue_free;
   logic           load;
   logic           accept;
   frame_eval_type eval;
   run_type        run;
   record_type     record;

   assign load           = in_valid_ff && queue_free;
   assign req_chan.ready = !in_valid_ff || load;
   assign accept         = req_chan.valid && req_chan.ready;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         power_wait_ff    <= POWER_WAIT_RESET;
         reply_timeout_ff <= REPLY_TIMEOUT_RESET;
         retry_limit_ff   <= RETRY_LIMIT_RESET;
         degree_limit_ff  <= DEGREE_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (reg_index_type'(csr_index))
            REG_POWER_WAIT:    power_wait_ff    <= csr_write_data;
            REG_REPLY_TIMEOUT: reply_timeout_ff <= csr_write_data;
            REG_RETRY_LIMIT:   retry_limit_ff   <= csr_write_data[3:0];
            REG_DEGREE_LIMIT:  degree_limit_ff  <= csr_write_data[9:0];
         endcase
      end
   end

   // Input register occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (load) begin
         in_valid_ff <= 1'b0;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.action          <= req_chan.action;
         item_ff.battery_level   <= req_chan.battery_level;
         item_ff.x_sign_hundreds <= req_chan.x_sign_hundreds;
         item_ff.x_degrees_low   <= req_chan.x_degrees_low;
         item_ff.x_fraction_high <= req_chan.x_fraction_high;
         item_ff.x_fraction_low  <= req_chan.x_fraction_low;
         item_ff.y_sign_hundreds <= req_chan.y_sign_hundreds;
         item_ff.y_degrees_low   <= req_chan.y_degrees_low;
         item_ff.y_fraction_high <= req_chan.y_fraction_high;
         item_ff.y_fraction_low  <= req_chan.y_fraction_low;
      end
   end

   ipr_frame_decode u_frame_decode (
      .item         (item_ff),
      .degree_limit (degree_limit_ff),
      .eval         (eval)
   );

   ipr_sequencer u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .item        (item_ff),
      .eval        (eval),
      .retry_limit (retry_limit_ff),
      .run         (run),
      .record      (record)
   );

   ipr_result_queue u_result_queue (
      .clock            (clock),
      .reset            (reset),
      .load             (load),
      .run              (run),
      .record           (record),
      .power_wait_ms    (power_wait_ff),
      .reply_timeout_ms (reply_timeout_ff),
      .free             (queue_free),
      .rsp              (rsp_chan)
   );

endmodule

`default_nettype wire
